FILE: sv/tsas_pkg.sv
// ----------------------------------------------------------------------------
// tsas_pkg
// Shared widths, register map and calibration defaults for the touch sample
// averaging and scaling block.
// ----------------------------------------------------------------------------
package tsas_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 16;
    localparam int COUNT_W    = 5;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int IDX_W      = 3;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 5'd16;

    localparam int SCREEN_WIDTH_DEF  = 480;
    localparam int SCREEN_HEIGHT_DEF = 272;

    localparam logic [SAMPLE_W-1:0] DEF_MIN_X = 12'd90;
    localparam logic [SAMPLE_W-1:0] DEF_MAX_X = 12'd945;
    localparam logic [SAMPLE_W-1:0] DEF_MIN_Y = 12'd105;
    localparam logic [SAMPLE_W-1:0] DEF_MAX_Y = 12'd830;

    localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCALE_ENABLE = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAL_MIN_X    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAL_MAX_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAL_MIN_Y    = 3'd4;
    localparam logic [IDX_W-1:0] REG_CAL_MAX_Y    = 3'd5;

    // clamp v into [lo, hi] (raise to lo first, then lower to hi), minus lo
    function automatic logic [SAMPLE_W-1:0] clamp_offset(
        input logic [SAMPLE_W-1:0] v,
        input logic [SAMPLE_W-1:0] lo,
        input logic [SAMPLE_W-1:0] hi
    );
        logic [SAMPLE_W-1:0] vc;
        vc = (v < lo) ? lo : v;
        vc = (vc > hi) ? hi : vc;
        return vc - lo;
    endfunction

endpackage

FILE: sv/touch_sample_average_and_scale_top.sv
// ----------------------------------------------------------------------------
// touch_sample_average_and_scale_top
// Sums sample_count touch words, then emits one rounded average, optionally
// clamped to calibration limits and scaled to the screen.
// ----------------------------------------------------------------------------
// Path: after the word that closes a set, the serial averaging divider runs;
// unscaled, its result then goes to the output register, while scaled, the clamp,
// a shift-add multiply and a serial scaling divider run before that load.
// Throughput: one word per cycle inside a set; input is held while a result is
// built and until the done state has loaded it into the output register.
// A finished result waits in the output register while new words are summed.
// Synchronous active-low reset clears sums, counters and m_tvalid; config resets, sample_count to one.
module touch_sample_average_and_scale_top #(
    parameter int SCREEN_WIDTH  = tsas_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tsas_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: raw_x[11:0], raw_y[23:12], raw_pressure[35:24], zero pad
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,
    // m_tdata: pos_x[11:0], pos_y[23:12], pressure[35:24], zero pad
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,
    // m_tuser: event_valid[0]
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsas_pkg::APB_AW-1:0] paddr,
    input  logic [tsas_pkg::APB_DW-1:0] pwdata,
    output logic [tsas_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int SW = tsas_pkg::SAMPLE_W;
    localparam int UW = tsas_pkg::SUM_W;
    localparam int NW = tsas_pkg::COUNT_W;
    localparam int PW = tsas_pkg::PROD_W;
    localparam int MCW = $clog2(SW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_AVG_WAIT,
        S_PREP,
        S_MUL,
        S_DIV,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [NW-1:0] sample_count_reg;
    logic          scale_enable_reg;
    logic [SW-1:0] cal_min_x_reg;
    logic [SW-1:0] cal_max_x_reg;
    logic [SW-1:0] cal_min_y_reg;
    logic [SW-1:0] cal_max_y_reg;

    // accumulation
    logic [UW-1:0] sum_x_reg;
    logic [UW-1:0] sum_y_reg;
    logic [UW-1:0] sum_p_reg;
    logic [NW-1:0] taken_reg;
    logic          zero_seen_reg;
    logic          zero_res_reg;

    // scaling datapath
    logic [SW-1:0] mcand_x_reg;
    logic [SW-1:0] mcand_y_reg;
    logic [SW-1:0] span_x_reg;
    logic [SW-1:0] span_y_reg;
    logic          ok_x_reg;
    logic          ok_y_reg;
    logic [SW-1:0] mplr_x_reg;
    logic [SW-1:0] mplr_y_reg;
    logic [PW-1:0] prod_x_reg;
    logic [PW-1:0] prod_y_reg;
    logic [MCW-1:0] mul_cnt_reg;

    logic          m_tvalid_reg;
    logic          m_tuser_reg;
    logic [SW-1:0] pos_x_reg;
    logic [SW-1:0] pos_y_reg;
    logic [SW-1:0] pres_reg;

    logic [SW-1:0] raw_x;
    logic [SW-1:0] raw_y;
    logic [SW-1:0] raw_p;
    logic          s_accept;
    logic [NW-1:0] n_eff;
    logic [UW-1:0] half;
    logic [UW-1:0] sum_x_new;
    logic [UW-1:0] sum_y_new;
    logic [UW-1:0] sum_p_new;
    logic [NW-1:0] taken_new;
    logic          zero_new;

    logic          avg_start;
    logic          avg_busy_x;
    logic          avg_busy_y;
    logic          avg_busy_p;
    logic          avg_busy;
    logic [UW-1:0] avg_q_x;
    logic [UW-1:0] avg_q_y;
    logic [UW-1:0] avg_q_p;

    logic          scl_start;
    logic          scl_busy_x;
    logic          scl_busy_y;
    logic [PW-1:0] scl_q_x;
    logic [PW-1:0] scl_q_y;

    logic          use_def;
    logic [SW-1:0] lo_x;
    logic [SW-1:0] hi_x;
    logic [SW-1:0] lo_y;
    logic [SW-1:0] hi_y;
    logic [SW-1:0] res_x;
    logic [SW-1:0] res_y;
    logic          cfg_wr;
    logic [tsas_pkg::IDX_W-1:0] cfg_idx;

    assign raw_x = s_tdata[SW-1:0];
    assign raw_y = s_tdata[2*SW-1:SW];
    assign raw_p = s_tdata[3*SW-1:2*SW];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // zero counts as one, anything past sixteen as sixteen
    always_comb begin
        if (sample_count_reg == '0) begin
            n_eff = NW'(1);
        end else if (sample_count_reg > tsas_pkg::MAX_COUNT) begin
            n_eff = tsas_pkg::MAX_COUNT;
        end else begin
            n_eff = sample_count_reg;
        end
    end

    assign half      = UW'(n_eff >> 1);
    assign sum_x_new = sum_x_reg + UW'(raw_x);
    assign sum_y_new = sum_y_reg + UW'(raw_y);
    assign sum_p_new = sum_p_reg + UW'(raw_p);
    assign taken_new = taken_reg + 1'b1;
    assign zero_new  = zero_seen_reg || (raw_x == '0) || (raw_y == '0) || (raw_p == '0);

    assign avg_start = (state_reg == S_AVG);
    assign scl_start = (state_reg == S_DIV);
    assign avg_busy  = avg_busy_x || avg_busy_y || avg_busy_p;

    tsas_div_lane #(.DW(UW), .VW(NW)) u_avg_x (
        .aclk(aclk), .aresetn(aresetn), .start(avg_start),
        .dividend(sum_x_reg), .divisor(n_eff), .busy(avg_busy_x), .quotient(avg_q_x)
    );
    tsas_div_lane #(.DW(UW), .VW(NW)) u_avg_y (
        .aclk(aclk), .aresetn(aresetn), .start(avg_start),
        .dividend(sum_y_reg), .divisor(n_eff), .busy(avg_busy_y), .quotient(avg_q_y)
    );
    tsas_div_lane #(.DW(UW), .VW(NW)) u_avg_p (
        .aclk(aclk), .aresetn(aresetn), .start(avg_start),
        .dividend(sum_p_reg), .divisor(n_eff), .busy(avg_busy_p), .quotient(avg_q_p)
    );

    tsas_div_lane #(.DW(PW), .VW(SW)) u_scl_x (
        .aclk(aclk), .aresetn(aresetn), .start(scl_start),
        .dividend(prod_x_reg), .divisor(span_x_reg), .busy(scl_busy_x), .quotient(scl_q_x)
    );
    tsas_div_lane #(.DW(PW), .VW(SW)) u_scl_y (
        .aclk(aclk), .aresetn(aresetn), .start(scl_start),
        .dividend(prod_y_reg), .divisor(span_y_reg), .busy(scl_busy_y), .quotient(scl_q_y)
    );

    // min_x of zero selects the built-in limits for both axes
    assign use_def = (cal_min_x_reg == '0);
    assign lo_x    = use_def ? tsas_pkg::DEF_MIN_X : cal_min_x_reg;
    assign hi_x    = use_def ? tsas_pkg::DEF_MAX_X : cal_max_x_reg;
    assign lo_y    = use_def ? tsas_pkg::DEF_MIN_Y : cal_min_y_reg;
    assign hi_y    = use_def ? tsas_pkg::DEF_MAX_Y : cal_max_y_reg;

    always_comb begin
        if (scale_enable_reg) begin
            res_x = ok_x_reg ? scl_q_x[SW-1:0] : '0;
            res_y = ok_y_reg ? scl_q_y[SW-1:0] : '0;
        end else begin
            res_x = avg_q_x[SW-1:0];
            res_y = avg_q_y[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_p_reg     <= '0;
            taken_reg     <= '0;
            zero_seen_reg <= 1'b0;
            mul_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // the done state handles its own handshake on the output word
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (taken_new >= n_eff) begin
                            // sums carry the rounding term into the dividers
                            sum_x_reg     <= sum_x_new + half;
                            sum_y_reg     <= sum_y_new + half;
                            sum_p_reg     <= sum_p_new + half;
                            zero_res_reg  <= zero_new;
                            zero_seen_reg <= 1'b0;
                            taken_reg     <= '0;
                            state_reg     <= S_AVG;
                        end else begin
                            sum_x_reg     <= sum_x_new;
                            sum_y_reg     <= sum_y_new;
                            sum_p_reg     <= sum_p_new;
                            zero_seen_reg <= zero_new;
                            taken_reg     <= taken_new;
                        end
                    end
                end
                S_AVG: begin
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    sum_p_reg <= '0;
                    state_reg <= S_AVG_WAIT;
                end
                S_AVG_WAIT: begin
                    if (!avg_busy) begin
                        state_reg <= scale_enable_reg ? S_PREP : S_DONE;
                    end
                end
                S_PREP: begin
                    mcand_x_reg <= tsas_pkg::clamp_offset(avg_q_x[SW-1:0], lo_x, hi_x);
                    mcand_y_reg <= tsas_pkg::clamp_offset(avg_q_y[SW-1:0], lo_y, hi_y);
                    span_x_reg  <= hi_x - lo_x;
                    span_y_reg  <= hi_y - lo_y;
                    ok_x_reg    <= hi_x > lo_x;
                    ok_y_reg    <= hi_y > lo_y;
                    mplr_x_reg  <= SW'(SCREEN_WIDTH);
                    mplr_y_reg  <= SW'(SCREEN_HEIGHT);
                    prod_x_reg  <= '0;
                    prod_y_reg  <= '0;
                    mul_cnt_reg <= MCW'(SW);
                    state_reg   <= S_MUL;
                end
                S_MUL: begin
                    // MSB-first shift-add, one multiplier bit per cycle
                    prod_x_reg  <= {prod_x_reg[PW-2:0], 1'b0}
                                 + (mplr_x_reg[SW-1] ? PW'(mcand_x_reg) : '0);
                    prod_y_reg  <= {prod_y_reg[PW-2:0], 1'b0}
                                 + (mplr_y_reg[SW-1] ? PW'(mcand_y_reg) : '0);
                    mplr_x_reg  <= {mplr_x_reg[SW-2:0], 1'b0};
                    mplr_y_reg  <= {mplr_y_reg[SW-2:0], 1'b0};
                    mul_cnt_reg <= mul_cnt_reg - 1'b1;
                    if (mul_cnt_reg == MCW'(1)) begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (!scl_busy_x && !scl_busy_y) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= !zero_res_reg;
                        pos_x_reg    <= zero_res_reg ? '0 : res_x;
                        pos_y_reg    <= zero_res_reg ? '0 : res_y;
                        pres_reg     <= zero_res_reg ? '0 : avg_q_p[SW-1:0];
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {4'b0000, pres_reg, pos_y_reg, pos_x_reg};

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[tsas_pkg::APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= NW'(1);
            scale_enable_reg <= 1'b0;
            cal_min_x_reg    <= '0;
            cal_max_x_reg    <= '0;
            cal_min_y_reg    <= '0;
            cal_max_y_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                tsas_pkg::REG_SAMPLE_COUNT: sample_count_reg <= pwdata[NW-1:0];
                tsas_pkg::REG_SCALE_ENABLE: scale_enable_reg <= pwdata[0];
                tsas_pkg::REG_CAL_MIN_X:    cal_min_x_reg    <= pwdata[SW-1:0];
                tsas_pkg::REG_CAL_MAX_X:    cal_max_x_reg    <= pwdata[SW-1:0];
                tsas_pkg::REG_CAL_MIN_Y:    cal_min_y_reg    <= pwdata[SW-1:0];
                tsas_pkg::REG_CAL_MAX_Y:    cal_max_y_reg    <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tsas_pkg::REG_SAMPLE_COUNT: prdata = tsas_pkg::APB_DW'(sample_count_reg);
            tsas_pkg::REG_SCALE_ENABLE: prdata = tsas_pkg::APB_DW'(scale_enable_reg);
            tsas_pkg::REG_CAL_MIN_X:    prdata = tsas_pkg::APB_DW'(cal_min_x_reg);
            tsas_pkg::REG_CAL_MAX_X:    prdata = tsas_pkg::APB_DW'(cal_max_x_reg);
            tsas_pkg::REG_CAL_MIN_Y:    prdata = tsas_pkg::APB_DW'(cal_min_y_reg);
            tsas_pkg::REG_CAL_MAX_Y:    prdata = tsas_pkg::APB_DW'(cal_max_y_reg);
            default:                    prdata = '0;
        endcase
    end

    // checks
    a_avg_busy_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        avg_busy |-> (state_reg == S_AVG_WAIT))
        else $error("averaging divider busy outside its wait state");

    a_taken_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (taken_reg < tsas_pkg::MAX_COUNT))
        else $error("sample count ran past the set size");

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata == '0))
        else $error("invalid event carries nonzero data");

    a_scaled_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg && scale_enable_reg) |->
        ((pos_x_reg <= SW'(SCREEN_WIDTH)) && (pos_y_reg <= SW'(SCREEN_HEIGHT))))
        else $error("scaled position beyond screen size");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("output word loaded outside the done state");

endmodule

FILE: sv/tsas_div_lane.sv
// ----------------------------------------------------------------------------
// tsas_div_lane
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsas_div_lane #(
    parameter int DW = 16,
    parameter int VW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    // dividend shifts out of the top while quotient bits shift in below
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
            quo_reg  <= dividend;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
